// ----- sv/sbis_pkg.sv -----
// Shared types and constants for the sorted bounded integer set.
package sbis_pkg;

   localparam int DEPTH      = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = CNT_W + 8;
   localparam int VALUE_W    = 32;
   localparam int DELTA_W    = 7;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int FIELD_W    = 6;
   localparam int CAP_RESET  = (DEPTH < 32) ? DEPTH : 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_ADJUST = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED     = 3'd0,
      STAT_PRESENT   = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_REMOVED   = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_ADJUSTED  = 3'd5
   } status_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage

// ----- sv/sbis_req_if.sv -----
// Request channel interface: kind, value and delta with valid/ready.
interface sbis_req_if import sbis_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic signed [VALUE_W-1:0]  value;
   logic signed [DELTA_W-1:0]  delta;

   modport source (output valid, output kind, output value, output delta, input ready);
   modport sink   (input valid, input kind, input value, input delta, output ready);
endinterface

// ----- sv/sbis_rsp_if.sv -----
// Response channel interface: status, count and capacity with valid/ready.
interface sbis_rsp_if import sbis_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [FIELD_W-1:0]   count;
   logic [FIELD_W-1:0]   capacity;

   modport source (output valid, output status, output count, output capacity, input ready);
   modport sink   (input valid, input status, input count, input capacity, output ready);
endinterface

// ----- sv/sorted_bounded_int_set.sv -----
// Top level of the sorted bounded integer set.
// A request is captured in ST_IDLE and executed in ST_EXEC, where the commit waits
// while an earlier response is still held; the response is then registered. The next
// request is accepted while a finished response waits in the output register.
// Reset: element count cleared, capacity loaded with 32 (saturated to DEPTH);
// cell contents stay undefined until written.
module sorted_bounded_int_set import sbis_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   sbis_req_if.sink            req_chan,
   sbis_rsp_if.source          rsp_chan,
   input  logic                csr_write_enable,
   input  logic [FIELD_W-1:0]  csr_write_data
);

   ctrl_cmd_type cmd;

   sbis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   sbis_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req_chan.kind),
      .req_value        (req_chan.value),
      .req_delta        (req_chan.delta),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_status       (rsp_chan.status),
      .rsp_count        (rsp_chan.count),
      .rsp_capacity     (rsp_chan.capacity)
   );

endmodule

// ----- sv/sbis_ctrl.sv -----
// Controller state machine: request capture, execute and response valid.
module sbis_ctrl import sbis_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      cmd.capture = req_valid && req_ready;
      cmd.commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
      state_in    = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/sbis_datapath.sv -----
// Datapath: sorted cell chain with per-cell compare and shift, count and capacity.
module sbis_datapath import sbis_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_cmd_type               cmd,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic signed [DELTA_W-1:0]  req_delta,
   input  logic                       csr_write_enable,
   input  logic [FIELD_W-1:0]         csr_write_data,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [FIELD_W-1:0]         rsp_count,
   output logic [FIELD_W-1:0]         rsp_capacity
);

   logic [KIND_W-1:0]          kind_ff;
   logic signed [VALUE_W-1:0]  value_ff;
   logic signed [DELTA_W-1:0]  delta_ff;
   logic [VALUE_W-1:0]         cells_ff [DEPTH];
   logic [VALUE_W-1:0]         cells_in [DEPTH];
   logic [DEPTH-1:0]           lt;
   logic [DEPTH-1:0]           eq;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           cap_ff, cap_in;
   logic [STATUS_W-1:0]        status_ff, status_in;
   logic [CNT_W-1:0]           out_count_ff, out_cap_ff;
   logic                       found, full, do_insert, do_remove;
   logic [SUM_W-1:0]           count_x, cap_x, delta_x, mag_x, sum_x, load_x;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic             valid;
      logic             prev_lt;
      logic [VALUE_W-1:0] prev_val, next_val;

      if (i == 0) begin : g_first
         assign prev_val = value_ff;
         assign prev_lt  = 1'b0;
      end else begin : g_mid
         assign prev_val = cells_ff[i-1];
         assign prev_lt  = lt[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_val = cells_ff[i];
      end else begin : g_inner
         assign next_val = cells_ff[i+1];
      end

      assign valid = (CNT_W'(i) < count_ff);
      assign lt[i] = valid && ($signed(cells_ff[i]) < value_ff);
      assign eq[i] = valid && (cells_ff[i] == value_ff);

      always_comb begin
         cells_in[i] = cells_ff[i];
         if (do_insert && !lt[i]) begin
            cells_in[i] = ((i == 0) || prev_lt) ? value_ff : prev_val;
         end else if (do_remove && !lt[i]) begin
            cells_in[i] = next_val;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.commit) cells_ff[i] <= cells_in[i];
      end
   end

   always_comb begin
      found     = |eq;
      full      = !((count_ff < cap_ff) && (count_ff < CNT_W'(DEPTH)));
      do_insert = 1'b0;
      do_remove = 1'b0;
      count_in  = count_ff;
      cap_in    = cap_ff;
      status_in = STAT_ADJUSTED;
      count_x   = SUM_W'(count_ff);
      cap_x     = SUM_W'(cap_ff);
      delta_x   = SUM_W'(delta_ff);
      mag_x     = SUM_W'(0) - delta_x;
      sum_x     = cap_x + delta_x;
      case (kind_ff)
         KIND_INSERT: begin
            if (found) begin
               status_in = STAT_PRESENT;
            end else if (!full) begin
               do_insert = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               status_in = STAT_ADDED;
            end else begin
               status_in = STAT_FULL;
            end
         end
         KIND_REMOVE: begin
            if (found) begin
               do_remove = 1'b1;
               count_in  = count_ff - CNT_W'(1);
               status_in = STAT_REMOVED;
            end else begin
               status_in = STAT_NOT_FOUND;
            end
            cap_in = count_in;
         end
         KIND_ADJUST: begin
            if (delta_ff < 0) begin
               if (cap_x >= count_x + mag_x) begin
                  cap_in = CNT_W'(cap_x - mag_x);
               end else begin
                  cap_in = count_ff;
               end
            end else if (delta_ff != 0) begin
               cap_in = (sum_x > SUM_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(sum_x);
            end
         end
         default: status_in = STAT_ADJUSTED;
      endcase
      load_x = SUM_W'(csr_write_data);
      if (load_x > SUM_W'(DEPTH)) load_x = SUM_W'(DEPTH);
      if (load_x < count_x) load_x = count_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CNT_W'(CAP_RESET);
      end else if (cmd.commit) begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end else if (csr_write_enable) begin
         cap_ff   <= CNT_W'(load_x);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
         delta_ff <= req_delta;
      end
      if (cmd.commit) begin
         status_ff    <= status_in;
         out_count_ff <= count_in;
         out_cap_ff   <= cap_in;
      end
   end

   assign rsp_status   = status_ff;
   assign rsp_count    = FIELD_W'(out_count_ff);
   assign rsp_capacity = FIELD_W'(out_cap_ff);

endmodule

// ----- sv/sbis_checker.sv -----
// Port-level assertions for the sorted bounded integer set, bound to the top level.
module sbis_assert_checker import sbis_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [FIELD_W-1:0]  rsp_count,
   input logic [FIELD_W-1:0]  rsp_capacity
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_count_in_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= rsp_capacity)
      else $error("count above capacity");

   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_capacity <= FIELD_W'(CAP_RESET))
      else $error("capacity above depth");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_REMOVED || rsp_status == STAT_NOT_FOUND)
      |-> rsp_capacity == rsp_count)
      else $error("remove left capacity above count");

   a_added_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_ADDED || rsp_status == STAT_PRESENT)
      |-> rsp_count != '0)
      else $error("insert reported with empty set");

endmodule

bind sorted_bounded_int_set sbis_assert_checker u_sbis_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_status   (rsp_chan.status),
   .rsp_count    (rsp_chan.count),
   .rsp_capacity (rsp_chan.capacity)
);
